### design/weighted_level_order_compare_core_defines.svh
// Assertion macros for the weighted level order compare RTL, used by wloc_merge.
// Depends on nothing; the including module provides clk_i and rst_ni.
`ifndef WEIGHTED_LEVEL_ORDER_COMPARE_CORE_DEFINES_SVH
`define WEIGHTED_LEVEL_ORDER_COMPARE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define WLOC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define WLOC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/wloc_pkg.sv
// Package for the weighted level order compare core: widths, codes, beat types.
// Used by every module of the block; depends on nothing.
package wloc_pkg;

  localparam int CodeWidth = 64;                 // 8 .. 64
  localparam int HalfW     = (CodeWidth + 1) / 2; // partial product operand width
  localparam int PartW     = 2 * HalfW;
  localparam int ExtW      = 4 * HalfW;
  localparam int ProdW     = 2 * CodeWidth;
  localparam int SumW      = 128;

  typedef enum logic [1:0] {
    ModeTerm  = 2'd0,
    ModeLevel = 2'd1,
    ModeKey   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StRange    = 2'd1,
    StOverflow = 2'd2
  } status_e;

  localparam logic signed [1:0] OrderLeft  = -2'sd1;
  localparam logic signed [1:0] OrderEqual = 2'sd0;
  localparam logic signed [1:0] OrderRight = 2'sd1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] left_code;
    logic [63:0] right_code;
    logic [63:0] weight;
    logic [63:0] max_code;
    logic [7:0]  left_byte;
    logic        left_byte_valid;
    logic [7:0]  right_byte;
    logic        right_byte_valid;
    logic        last;
  } in_beat_t;

  typedef struct packed {
    logic signed [1:0] order;
    logic [1:0]        status;
  } out_beat_t;

  // Non-arithmetic part of a beat, carried alongside the multiplier lanes.
  typedef struct packed {
    logic       valid;
    logic [1:0] mode;
    logic [7:0] left_byte;
    logic       left_byte_valid;
    logic [7:0] right_byte;
    logic       right_byte_valid;
    logic       last;
  } meta_t;

endpackage

### design/weighted_level_order_compare_core.sv
// Weighted level order compare core: takes one beat per clock and returns one result
// beat per request, on its last beat, after both lane stages and the merge stage. Two
// multiplier lanes (left and right candidate) build code*weight from four registered
// half-width partial products and check the code against max_code; the merge stage
// then adds both products into 128-bit level sums, judges levels and key bytes, and
// loads the result register. The sustained rate is one beat per cycle, set by the
// lane pipelines and the two 128-bit adds and compare of the merge stage; the input
// stalls only while the result register holds an unread beat and out_stall_i is high.
// Depends on wloc_pkg, wloc_lane and wloc_merge.
module weighted_level_order_compare_core import wloc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  logic             en;
  meta_t            meta_in, meta1_q, meta2_q;
  logic [ProdW-1:0] left_prod, right_prod;
  logic             left_range, right_range;

  // whole pipe advances together; it only holds behind a stalled result
  assign in_stall_o = !en;

  assign meta_in = '{
    valid:            in_valid_i,
    mode:             in_beat_i.mode,
    left_byte:        in_beat_i.left_byte,
    left_byte_valid:  in_beat_i.left_byte_valid,
    right_byte:       in_beat_i.right_byte,
    right_byte_valid: in_beat_i.right_byte_valid,
    last:             in_beat_i.last
  };

  // beat control travels two stages, in step with the lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta1_q <= '0;
      meta2_q <= '0;
    end else if (en) begin
      meta1_q <= meta_in;
      meta2_q <= meta1_q;
    end
  end

  // left candidate lane
  wloc_lane u_lane_left (
    .clk_i         (clk_i),
    .en_i          (en),
    .code_i        (in_beat_i.left_code[CodeWidth-1:0]),
    .weight_i      (in_beat_i.weight[CodeWidth-1:0]),
    .max_code_i    (in_beat_i.max_code[CodeWidth-1:0]),
    .prod_o        (left_prod),
    .range_fault_o (left_range)
  );

  // right candidate lane
  wloc_lane u_lane_right (
    .clk_i         (clk_i),
    .en_i          (en),
    .code_i        (in_beat_i.right_code[CodeWidth-1:0]),
    .weight_i      (in_beat_i.weight[CodeWidth-1:0]),
    .max_code_i    (in_beat_i.max_code[CodeWidth-1:0]),
    .prod_o        (right_prod),
    .range_fault_o (right_range)
  );

  // sums, decision and result register
  wloc_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .meta_i        (meta2_q),
    .left_prod_i   (left_prod),
    .left_range_i  (left_range),
    .right_prod_i  (right_prod),
    .right_range_i (right_range),
    .en_o          (en),
    .out_valid_o   (out_valid_o),
    .out_beat_o    (out_beat_o),
    .out_stall_i   (out_stall_i)
  );

endmodule

### design/wloc_lane.sv
// One multiplier lane: range check and code*weight over two pipeline stages.
// Depends on wloc_pkg.
module wloc_lane import wloc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [CodeWidth-1:0] code_i,
  input  logic [CodeWidth-1:0] weight_i,
  input  logic [CodeWidth-1:0] max_code_i,
  output logic [ProdW-1:0]     prod_o,
  output logic                 range_fault_o
);

  logic [HalfW-1:0] a_lo, a_hi, b_lo, b_hi;
  logic [PartW-1:0] p00_q, p01_q, p10_q, p11_q;
  logic             fault1_q, fault2_q;
  logic [ExtW-1:0]  prod_full;
  logic [ProdW-1:0] prod_q;

  assign a_lo = code_i[HalfW-1:0];
  assign a_hi = HalfW'(code_i >> HalfW);
  assign b_lo = weight_i[HalfW-1:0];
  assign b_hi = HalfW'(weight_i >> HalfW);

  // stage 1: four half-width partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p00_q    <= PartW'(a_lo) * PartW'(b_lo);
      p01_q    <= PartW'(a_lo) * PartW'(b_hi);
      p10_q    <= PartW'(a_hi) * PartW'(b_lo);
      p11_q    <= PartW'(a_hi) * PartW'(b_hi);
      fault1_q <= code_i > max_code_i;
    end
  end

  assign prod_full = ExtW'(p00_q)
                   + ((ExtW'(p01_q) + ExtW'(p10_q)) << HalfW)
                   + (ExtW'(p11_q) << (2 * HalfW));

  // stage 2: full product
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q   <= prod_full[ProdW-1:0];
      fault2_q <= fault1_q;
    end
  end

  assign prod_o        = prod_q;
  assign range_fault_o = fault2_q;

endmodule

### design/wloc_merge.sv
// Merge stage: level sums, faults, decision state and the result register.
// Depends on wloc_pkg and weighted_level_order_compare_core_defines.svh.
`include "weighted_level_order_compare_core_defines.svh"

module wloc_merge import wloc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  meta_t            meta_i,
  input  logic [ProdW-1:0] left_prod_i,
  input  logic             left_range_i,
  input  logic [ProdW-1:0] right_prod_i,
  input  logic             right_range_i,
  output logic             en_o,
  output logic             out_valid_o,
  output out_beat_t        out_beat_o,
  input  logic             out_stall_i
);

  logic [SumW-1:0]   left_total_q, left_total_d, right_total_q, right_total_d;
  status_e           left_fault_q, left_fault_d, right_fault_q, right_fault_d;
  logic              decided_q, decided_d;
  logic signed [1:0] held_order_q, held_order_d;
  status_e           held_status_q, held_status_d;
  logic              out_valid_q;
  out_beat_t         out_q, out_d;
  logic [SumW:0]     left_sum, right_sum;
  logic              active;

  assign en_o   = !(out_valid_q && out_stall_i);
  assign active = meta_i.valid && en_o;

  assign left_sum  = {1'b0, left_total_q} + (SumW + 1)'(left_prod_i);
  assign right_sum = {1'b0, right_total_q} + (SumW + 1)'(right_prod_i);

  always_comb begin
    left_total_d  = left_total_q;
    right_total_d = right_total_q;
    left_fault_d  = left_fault_q;
    right_fault_d = right_fault_q;
    decided_d     = decided_q;
    held_order_d  = held_order_q;
    held_status_d = held_status_q;
    out_d         = out_q;

    if (active && !decided_q) begin
      case (meta_i.mode)
        ModeTerm: begin
          if (left_fault_q == StOk) begin
            if (left_range_i)          left_fault_d = StRange;
            else if (left_sum[SumW])   left_fault_d = StOverflow;
            else                       left_total_d = left_sum[SumW-1:0];
          end
          if (right_fault_q == StOk) begin
            if (right_range_i)         right_fault_d = StRange;
            else if (right_sum[SumW])  right_fault_d = StOverflow;
            else                       right_total_d = right_sum[SumW-1:0];
          end
        end
        ModeLevel: begin
          if (left_fault_q != StOk) begin
            decided_d     = 1'b1;
            held_order_d  = OrderEqual;
            held_status_d = left_fault_q;
          end else if (right_fault_q != StOk) begin
            decided_d     = 1'b1;
            held_order_d  = OrderEqual;
            held_status_d = right_fault_q;
          end else if (left_total_q != right_total_q) begin
            decided_d     = 1'b1;
            held_order_d  = (left_total_q < right_total_q) ? OrderLeft : OrderRight;
            held_status_d = StOk;
          end
          left_total_d  = '0;
          right_total_d = '0;
          left_fault_d  = StOk;
          right_fault_d = StOk;
        end
        ModeKey: begin
          if (meta_i.left_byte_valid && meta_i.right_byte_valid) begin
            if (meta_i.left_byte != meta_i.right_byte) begin
              decided_d     = 1'b1;
              held_order_d  = (meta_i.left_byte < meta_i.right_byte) ? OrderLeft
                                                                      : OrderRight;
              held_status_d = StOk;
            end
          end else if (meta_i.left_byte_valid) begin
            decided_d     = 1'b1;
            held_order_d  = OrderRight;
            held_status_d = StOk;
          end else if (meta_i.right_byte_valid) begin
            decided_d     = 1'b1;
            held_order_d  = OrderLeft;
            held_status_d = StOk;
          end
        end
        default: begin
        end
      endcase
    end

    // last beat: emit the outcome and return to the idle request state
    if (active && meta_i.last) begin
      if (decided_d) begin
        out_d.status = held_status_d;
        out_d.order  = (held_status_d != StOk) ? OrderEqual : held_order_d;
      end else begin
        out_d.status = StOk;
        out_d.order  = OrderEqual;
      end
      left_total_d  = '0;
      right_total_d = '0;
      left_fault_d  = StOk;
      right_fault_d = StOk;
      decided_d     = 1'b0;
      held_order_d  = OrderEqual;
      held_status_d = StOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_total_q  <= '0;
      right_total_q <= '0;
      left_fault_q  <= StOk;
      right_fault_q <= StOk;
      decided_q     <= 1'b0;
      held_order_q  <= OrderEqual;
      held_status_q <= StOk;
      out_valid_q   <= 1'b0;
    end else begin
      left_total_q  <= left_total_d;
      right_total_q <= right_total_d;
      left_fault_q  <= left_fault_d;
      right_fault_q <= right_fault_d;
      decided_q     <= decided_d;
      held_order_q  <= held_order_d;
      held_status_q <= held_status_d;
      if (en_o) begin
        out_valid_q <= meta_i.valid && meta_i.last;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  `WLOC_ASSERT_NEXT(a_out_follows_last, en_o, out_valid_q == $past(meta_i.valid && meta_i.last), "result beat does not match a last beat")
  `WLOC_ASSERT_NEXT(a_clear_after_last, active && meta_i.last, !decided_q && left_total_q == '0 && right_total_q == '0 && left_fault_q == StOk, "request state not cleared after last beat")
  `WLOC_ASSERT_NEXT(a_decision_sticks, decided_q && !(active && meta_i.last), decided_q && $stable(held_order_q) && $stable(held_status_q), "decision changed within a request")
  `WLOC_ASSERT_NOW(a_fault_order_zero, out_valid_q && out_q.status != StOk, out_q.order == OrderEqual, "faulty result carries nonzero order")
  `WLOC_ASSERT_NOW(a_order_legal, out_valid_q, out_q.order != 2'b10 && out_q.status != 2'b11, "illegal result code")

endmodule

### tb/sv/weighted_level_order_compare_core_test.sv
// Self-checking testbench for weighted_level_order_compare_core: streams weighted-sum
// levels and key byte pairs through valid/stall and checks each order/status beat.
// Depends on wloc_pkg and the core RTL only.
module weighted_level_order_compare_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import wloc_pkg::*;

  localparam logic [1:0]  ModeSpare     = 2'd3;  // unused mode, ignored by the block
  localparam logic [63:0] AllOnes       = '1;
  localparam int          WideW         = SumW + 1;
  localparam int          RandomItems   = 260;   // per random traffic pass
  localparam int          HoldCycles    = 200;   // long receiver hold-off
  localparam int          DrainSlack    = 8;     // margin after the last result drains
  localparam int          WatchdogLimit = 3000;  // cycles with no beat moving
  localparam int          ReportMax     = 10;

  typedef enum int {StallNone, StallLight, StallHeavy, StallPeriodic} stall_style_e;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_beat_t  in_beat_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_beat_t out_beat_o;

  weighted_level_order_compare_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: per-level 128-bit sums, per-side first fault, and the outcome
  // once a level or a key byte has decided the request.
  // ---------------------------------------------------------------------------
  logic [SumW-1:0]   sum_left, sum_right;
  status_e           fault_left, fault_right;
  bit                outcome_set;
  logic signed [1:0] outcome_order;
  status_e           outcome_status;

  out_beat_t pending_verdicts[$];  // order/status beats still owed by the core

  int fail_count   = 0;
  int report_count = 0;
  int items_sent   = 0;

  // Knobs shared between the stimulus tasks and the idling processes.
  bit tx_idle_en   = 1'b1;
  int burst_left   = 0;
  bit rx_idle_en   = 1'b1;
  int hold_request = 0;

  function automatic void clear_level();
    sum_left    = '0;
    sum_right   = '0;
    fault_left  = StOk;
    fault_right = StOk;
  endfunction

  function automatic void clear_request();
    clear_level();
    outcome_set    = 1'b0;
    outcome_order  = OrderEqual;
    outcome_status = StOk;
  endfunction

  function automatic void settle(input logic signed [1:0] ord, input status_e st);
    outcome_set    = 1'b1;
    outcome_order  = ord;
    outcome_status = st;
  endfunction

  // Adds code*weight into one side's sum. A side keeps its first fault and stops
  // accumulating; a carry out of bit 127 is an overflow and leaves the sum alone.
  function automatic status_e accumulate(input logic [SumW-1:0] total,
                                         input status_e fault,
                                         input logic [CodeWidth-1:0] code,
                                         input logic [CodeWidth-1:0] weight,
                                         input logic [CodeWidth-1:0] limit,
                                         output logic [SumW-1:0] next_total);
    logic [WideW-1:0] wide;
    next_total = total;
    if (fault != StOk) return fault;
    if (code > limit) return StRange;
    wide = {1'b0, total} + WideW'(code) * WideW'(weight);
    if (wide[SumW]) return StOverflow;
    next_total = wide[SumW-1:0];
    return StOk;
  endfunction

  // Applies one accepted beat; on a last beat queues the verdict and starts over.
  function automatic void judge_beat(input in_beat_t b);
    logic [CodeWidth-1:0] lc, rc, w, mx;
    out_beat_t verdict;
    lc = b.left_code[CodeWidth-1:0];
    rc = b.right_code[CodeWidth-1:0];
    w  = b.weight[CodeWidth-1:0];
    mx = b.max_code[CodeWidth-1:0];
    if (!outcome_set) begin
      case (b.mode)
        ModeTerm: begin
          fault_left  = accumulate(sum_left, fault_left, lc, w, mx, sum_left);
          fault_right = accumulate(sum_right, fault_right, rc, w, mx, sum_right);
        end
        ModeLevel: begin
          // left fault wins over right fault, faults win over sums
          if (fault_left != StOk) settle(OrderEqual, fault_left);
          else if (fault_right != StOk) settle(OrderEqual, fault_right);
          else if (sum_left != sum_right)
            settle((sum_left < sum_right) ? OrderLeft : OrderRight, StOk);
          clear_level();
        end
        ModeKey: begin
          if (b.left_byte_valid && b.right_byte_valid) begin
            if (b.left_byte != b.right_byte)
              settle((b.left_byte < b.right_byte) ? OrderLeft : OrderRight, StOk);
          end else if (b.left_byte_valid) begin
            settle(OrderRight, StOk);  // right key is a proper prefix
          end else if (b.right_byte_valid) begin
            settle(OrderLeft, StOk);
          end
        end
        default: ;
      endcase
    end
    if (b.last) begin
      verdict.status = outcome_set ? outcome_status : StOk;
      verdict.order  = (outcome_set && outcome_status == StOk) ? outcome_order : OrderEqual;
      pending_verdicts.insert(pending_verdicts.size(), verdict);
      clear_request();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Beat builders. Fields a mode ignores are left random so every bit toggles.
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic in_beat_t noise_beat();
    in_beat_t b;
    b.mode             = 2'($urandom_range(0, 3));
    b.left_code        = rand_word();
    b.right_code       = rand_word();
    b.weight           = rand_word();
    b.max_code         = rand_word();
    b.left_byte        = 8'($urandom());
    b.left_byte_valid  = 1'($urandom());
    b.right_byte       = 8'($urandom());
    b.right_byte_valid = 1'($urandom());
    b.last             = 1'b0;
    return b;
  endfunction

  function automatic in_beat_t term_beat(input logic [63:0] lc, input logic [63:0] rc,
                                         input logic [63:0] w, input logic [63:0] mx);
    in_beat_t b;
    b            = noise_beat();
    b.mode       = ModeTerm;
    b.left_code  = lc;
    b.right_code = rc;
    b.weight     = w;
    b.max_code   = mx;
    return b;
  endfunction

  function automatic in_beat_t level_beat();
    in_beat_t b;
    b      = noise_beat();
    b.mode = ModeLevel;
    return b;
  endfunction

  function automatic in_beat_t key_beat(input logic [7:0] lb, input logic lv,
                                        input logic [7:0] rb, input logic rv);
    in_beat_t b;
    b                  = noise_beat();
    b.mode             = ModeKey;
    b.left_byte        = lb;
    b.left_byte_valid  = lv;
    b.right_byte       = rb;
    b.right_byte_valid = rv;
    return b;
  endfunction

  function automatic in_beat_t spare_beat();
    in_beat_t b;
    b      = noise_beat();
    b.mode = ModeSpare;
    return b;
  endfunction

  // scale 0: tiny codes so levels tie and keys get compared; 1: 32-bit; 2: full width,
  // where a few terms run the 128-bit sum over.
  function automatic in_beat_t random_term(input int scale);
    logic [63:0] lc, rc, w, mx;
    case (scale)
      0: begin
        lc = 64'($urandom_range(0, 7));
        rc = 64'($urandom_range(0, 7));
        w  = 64'($urandom_range(0, 3));
      end
      1: begin
        lc = 64'($urandom());
        rc = 64'($urandom());
        w  = 64'($urandom());
      end
      default: begin
        lc = rand_word();
        rc = rand_word();
        w  = rand_word();
      end
    endcase
    if ($urandom_range(0, 2) == 0) rc = lc;
    case ($urandom_range(0, 9))
      0:       mx = rand_word() >> $urandom_range(0, 63);  // often out of range
      1:       mx = AllOnes;
      default: mx = ((lc > rc) ? lc : rc) | 64'($urandom_range(0, 3));
    endcase
    return term_beat(lc, rc, w, mx);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps. Valid stays high between
  // back-to-back beats; it is only lowered at the start of a gap.
  // ---------------------------------------------------------------------------
  task automatic send_beat(input in_beat_t b, input bit last = 1'b0);
    int gap;
    if (tx_idle_en && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
    end
    b.last = last;
    in_valid_i <= 1'b1;
    in_beat_i  <= b;
    // in_stall_o read here is the value the edge sampled
    do @(posedge clk_i); while (in_stall_o);
    judge_beat(b);
    if (burst_left != 0) burst_left--;
  endtask

  task automatic pause_until_drained();
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  // One comparison request: mostly well-formed levels and keys with random content,
  // some with a trailing unjudged level or a stray spare-mode beat, some pure noise.
  task automatic send_request();
    in_beat_t    seq[$];
    int          style, scale, n_levels, llen, rlen, n_pairs;
    logic [7:0]  lkey[5], rkey[5];
    style = $urandom_range(0, 9);
    if (style == 0) begin
      repeat ($urandom_range(1, 6)) seq.insert(seq.size(), noise_beat());
    end else begin
      n_levels = $urandom_range(0, 3);
      for (int lv = 0; lv < n_levels; lv++) begin
        scale = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 2);
        repeat ($urandom_range(1, 4)) seq.insert(seq.size(), random_term(scale));
        if (!(style == 1 && lv == n_levels - 1)) seq.insert(seq.size(), level_beat());
      end
      llen = $urandom_range(0, 4);
      rlen = $urandom_range(0, 4);
      for (int k = 0; k < 5; k++) begin
        lkey[k] = 8'($urandom());
        rkey[k] = ($urandom_range(0, 3) != 0) ? lkey[k] : 8'($urandom());
      end
      n_pairs = ((llen > rlen) ? llen : rlen) + $urandom_range(0, 1);
      for (int k = 0; k < n_pairs; k++)
        seq.insert(seq.size(), key_beat(lkey[k], k < llen, rkey[k], k < rlen));
      if (style == 2) seq.insert($urandom_range(0, seq.size()), spare_beat());
    end
    if (seq.size() == 0) seq.insert(0, noise_beat());
    foreach (seq[i]) send_beat(seq[i], i == seq.size() - 1);
    items_sent += seq.size();
  endtask

  // ---------------------------------------------------------------------------
  // Test tasks
  // ---------------------------------------------------------------------------

  // Level sums: unjudged level, a deciding level, a tie followed by a decision.
  task automatic test_level_order();
    send_beat(term_beat(5, 3, 2, 10), 1'b1);            // never judged: equal
    send_beat(term_beat(5, 3, 2, 10));
    send_beat(level_beat(), 1'b1);                      // 10 vs 6: right first
    send_beat(term_beat(2, 3, 4, 10));
    send_beat(term_beat(3, 2, 4, 10));
    send_beat(level_beat());                            // 20 vs 20: tie
    send_beat(term_beat(1, 4, 1, 9));
    send_beat(level_beat(), 1'b1);                      // left first
  endtask

  // Faults: overflow on both sides, left range, right range, left beats right.
  task automatic test_fault_reporting();
    send_beat(term_beat(AllOnes, AllOnes, AllOnes, AllOnes));
    send_beat(term_beat(AllOnes, AllOnes, AllOnes, AllOnes));
    send_beat(level_beat(), 1'b1);
    send_beat(term_beat(1, 0, 7, 0));
    send_beat(level_beat());
    send_beat(key_beat(8'h00, 1'b1, 8'hFF, 1'b1), 1'b1);  // after the decision: ignored
    send_beat(term_beat(0, 9, 1, 8));
    send_beat(level_beat(), 1'b1);
    send_beat(term_beat(AllOnes, 0, AllOnes, AllOnes));
    send_beat(term_beat(AllOnes, 0, AllOnes, AllOnes)); // left overflows
    send_beat(term_beat(0, 5, 1, 4));                   // right out of range
    send_beat(level_beat(), 1'b1);
  endtask

  // Key bytes: byte extremes, empty pairs, spare mode, and the shorter-prefix rule.
  task automatic test_key_order();
    send_beat(level_beat());
    send_beat(key_beat(8'h00, 1'b1, 8'h00, 1'b1));
    send_beat(key_beat(8'h00, 1'b1, 8'hFF, 1'b1));
    send_beat(key_beat(8'hFF, 1'b0, 8'h00, 1'b0), 1'b1);
    send_beat(key_beat(8'h41, 1'b1, 8'h41, 1'b1));
    send_beat(key_beat(8'hAA, 1'b0, 8'h55, 1'b0));      // neither byte: no effect
    send_beat(spare_beat());
    send_beat(key_beat(8'h7F, 1'b1, 8'h80, 1'b0));      // right key ran out
    send_beat(spare_beat(), 1'b1);
  endtask

  task automatic test_random_traffic();
    items_sent = 0;
    while (items_sent < RandomItems) send_request();
  endtask

  // Receiver holds off while the sender streams short requests without gaps, so
  // the result register fills and the core stalls its input; then drain fully.
  task automatic test_fill_and_drain();
    tx_idle_en   = 1'b0;
    hold_request = HoldCycles;
    repeat (40) begin
      case ($urandom_range(0, 2))
        0:       send_beat(level_beat(), 1'b1);
        1:       send_beat(key_beat(8'($urandom()), 1'($urandom()),
                                    8'($urandom()), 1'($urandom())), 1'b1);
        default: begin
          send_beat(random_term(0));
          send_beat(level_beat(), 1'b1);
        end
      endcase
    end
    pause_until_drained();
    tx_idle_en = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver stall pattern: the style changes at random intervals; a hold request
  // from a test overrides it for that many cycles.
  // ---------------------------------------------------------------------------
  initial begin
    stall_style_e style;
    int           style_left;
    int           hold_left;
    int           phase;
    style      = StallNone;
    style_left = 0;
    hold_left  = 0;
    phase      = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (style_left == 0) begin
        style      = stall_style_e'($urandom_range(0, 3));
        style_left = $urandom_range(20, 120);
      end
      style_left--;
      phase++;
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (!rx_idle_en) begin
        out_stall_i <= 1'b0;
      end else begin
        case (style)
          StallLight:    out_stall_i <= ($urandom_range(0, 3) == 0);
          StallHeavy:    out_stall_i <= ($urandom_range(0, 3) != 0);
          StallPeriodic: out_stall_i <= ((phase % 5) < 2);
          default:       out_stall_i <= 1'b0;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result beat against the oldest verdict.
  // ---------------------------------------------------------------------------
  out_beat_t wanted;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_verdicts.size() == 0) begin
        fail_count++;
        if (report_count < ReportMax) begin
          report_count++;
          $display("%0t: result beat with nothing pending: order %0d status %0d",
                   $realtime, $signed(out_beat_o.order), out_beat_o.status);
        end
      end else begin
        wanted = pending_verdicts.pop_front();
        if (out_beat_o.order !== wanted.order || out_beat_o.status !== wanted.status) begin
          fail_count++;
          if (report_count < ReportMax) begin
            report_count++;
            $display("%0t: mismatch order exp %0d got %0d, status exp %0d got %0d",
                     $realtime, $signed(wanted.order), $signed(out_beat_o.order),
                     wanted.status, out_beat_o.status);
          end
        end
      end
    end
  end

  // Watchdog: ends the run once no beat has moved on either side for too long.
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == WatchdogLimit) begin
        $display("[weighted_level_order_compare_core] ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    clear_request();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_level_order();
    test_fault_reporting();
    test_key_order();
    test_random_traffic();
    test_fill_and_drain();
    test_random_traffic();

    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DrainSlack) @(posedge clk_i);
    if (fail_count == 0 && pending_verdicts.size() == 0) begin
      $display("[weighted_level_order_compare_core] OK");
    end else begin
      $display("[weighted_level_order_compare_core] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/wloc_pkg.sv
design/wloc_lane.sv
design/wloc_merge.sv
design/weighted_level_order_compare_core.sv
tb/sv/weighted_level_order_compare_core_test.sv
